// ----- rtl/core/mdp_tmu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_tmu_pkg
// Shared types and fixed-point constants of the transition model update block.
// ----------------------------------------------------------------------------
package mdp_tmu_pkg;

  localparam int PROB_W   = 17;
  localparam int REWARD_W = 24;
  localparam int DRAW_W   = 16;
  localparam int CMD_W    = 3;

  localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [PROB_W-1:0] TOL_Q16 = 17'd655;
  localparam logic [PROB_W-1:0] ALPHA_RESET = 17'd6554;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_PROB   = 3'd0,
    CMD_WR_REWARD = 3'd1,
    CMD_OBSERVE   = 3'd2,
    CMD_SAMPLE    = 3'd3,
    CMD_READ      = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_OBS_RD,
    ST_OBS_MUL,
    ST_OBS_WR,
    ST_OBS_CHK,
    ST_NRM_RD,
    ST_NRM_LD,
    ST_NRM_DIV,
    ST_NRM_WR,
    ST_SMP_RD,
    ST_SMP_CHK,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/mdp_transition_model_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_transition_model_update
// Learned next-state probabilities and expected rewards per state-action pair.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_* channel (valid/ready); each accepted beat
//   gives exactly one result beat on the out_* channel. The cfg_* channel
//   writes the step size alpha (Q1.16, saturated to 1.0); it is always ready.
//   One command is worked on at a time; the next one is taken as soon as the
//   previous has placed its result in the output register, even while that
//   result still waits for out_ready. A stalled receiver holds the result and,
//   once the next command is done, holds that command in its final state.
//   Write and read touch one entry; out-of-range or unknown commands go
//   straight to the result; sample walks the row until the draw is passed;
//   observe walks the row once and, when it is rescaled, once more to divide.
//   The probability memory has one read and one write port; every row walk
//   reads one entry at a time. Renormalize runs a restoring divider, one
//   quotient bit per cycle over 18 bits, for each entry of the row.
//   Reset clears the control state and sets alpha to 6554; both tables are
//   undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
module mdp_transition_model_update
  import mdp_tmu_pkg::*;
#(
  parameter int NUM_STATES  = 16,
  parameter int NUM_ACTIONS = 4,
  localparam int SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1,
  localparam int AW    = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1,
  localparam int RDEPTH = NUM_STATES * NUM_ACTIONS,
  localparam int PDEPTH = RDEPTH * NUM_STATES,
  localparam int RAW   = $clog2(RDEPTH),
  localparam int PAW   = $clog2(PDEPTH),
  localparam int SUMW  = SW + PROB_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [PROB_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CMD_W-1:0]           command,
  input  logic [SW-1:0]              state_index,
  input  logic [AW-1:0]              action_index,
  input  logic [SW-1:0]              next_state,
  input  logic signed [REWARD_W-1:0] reward_value,
  input  logic [PROB_W-1:0]          probability_value,
  input  logic [DRAW_W-1:0]          random_draw,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SW-1:0]              sampled_state,
  output logic [PROB_W-1:0]          probability_out,
  output logic signed [REWARD_W-1:0] expected_reward,
  output logic                       renormalized
);

  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_STATES - 1);

  // Tables
  logic [PROB_W-1:0]   p_mem [PDEPTH];
  logic [REWARD_W-1:0] r_mem [RDEPTH];
  logic [PROB_W-1:0]   p_rdata;
  logic signed [REWARD_W-1:0] r_rdata;
  logic                p_we, r_we;
  logic [PAW-1:0]      p_raddr, p_waddr;
  logic [PROB_W-1:0]   p_wdata;
  logic [RAW-1:0]      r_raddr;
  logic signed [REWARD_W-1:0] r_wdata;

  // Control and work registers
  state_t state, state_next;
  cmd_t   cmd_q, cmd_next;
  logic [PAW-1:0] row_base, row_base_next;
  logic [RAW-1:0] pair_q, pair_next;
  logic [SW-1:0]  s2_q, s2_next;
  logic signed [REWARD_W-1:0] rwd_q, rwd_next;
  logic [PROB_W-1:0] pv_q, pv_next;
  logic [DRAW_W-1:0] draw_q, draw_next;
  logic [PROB_W-1:0] alpha;
  logic [SW-1:0]  idx, idx_next;
  logic [SUMW-1:0] sum, sum_next;
  logic [PROB_W-1:0] p_cur, p_cur_next;
  logic [2*PROB_W-1:0] prod, prod_next;
  logic signed [42:0] rprod, rprod_next;
  logic [SUMW-1:0] div_rem, div_rem_next;
  logic [17:0] div_lo, div_lo_next;
  logic [17:0] div_q, div_q_next;
  logic [4:0]  div_cnt, div_cnt_next;
  logic        div_sat, div_sat_next;
  logic [SW-1:0] res_sampled, res_sampled_next;
  logic [PROB_W-1:0] res_pout, res_pout_next;
  logic signed [REWARD_W-1:0] res_rout, res_rout_next;
  logic        res_renorm, res_renorm_next;
  logic        out_load;

  // Input decode
  logic           accept;
  logic           bad_item;
  logic [RAW-1:0] pair_in;

  // Datapath temporaries
  logic [PROB_W-1:0]   mul_op;
  logic [18:0]         inc;
  logic [18:0]         p_new;
  logic [PROB_W-1:0]   p_new_sat;
  logic [SUMW-1:0]     sum_acc;
  logic [SUMW-1:0]     dev;
  logic signed [REWARD_W:0] rdiff;
  logic signed [26:0]  rstep;
  logic signed [27:0]  rnew;
  logic signed [REWARD_W-1:0] rnew_sat;
  logic [33:0]         num;
  logic [SUMW:0]       trial;
  logic [SUMW-1:0]     smp_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;

  assign bad_item = (command > CMD_READ)
                 || ({1'b0, state_index} >= (SW+1)'(NUM_STATES))
                 || ({1'b0, next_state} >= (SW+1)'(NUM_STATES))
                 || ({1'b0, action_index} >= (AW+1)'(NUM_ACTIONS));
  assign pair_in  = RAW'(RAW'(state_index) * RAW'(NUM_ACTIONS) + RAW'(action_index));

  // Step size register: saturate to 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alpha <= (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_waddr] <= p_wdata;
    end
    p_rdata <= p_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      r_mem[pair_q] <= r_wdata;
    end
    r_rdata <= r_mem[r_raddr];
  end

  // Hold the pair address so reward data stays valid through the command
  assign r_raddr = (state == ST_IDLE) ? pair_in : pair_q;

  // Shared arithmetic
  always_comb begin
    mul_op    = (idx == s2_q) ? (ONE_Q16 - p_rdata) : p_rdata;
    inc       = 19'((prod + 34'd32768) >> 16);
    p_new     = (idx == s2_q) ? (19'(p_cur) + inc) : (19'(p_cur) - inc);
    p_new_sat = (p_new > 19'(ONE_Q16)) ? ONE_Q16 : p_new[PROB_W-1:0];
    sum_acc   = sum + SUMW'(p_new_sat);
    dev       = (sum > SUMW'(ONE_Q16)) ? (sum - SUMW'(ONE_Q16)) : (SUMW'(ONE_Q16) - sum);
    rdiff     = (REWARD_W+1)'(rwd_q) - (REWARD_W+1)'(r_rdata);
    rstep     = 27'((rprod + 43'sd32768) >>> 16);
    rnew      = 28'(r_rdata) + 28'(rstep);
    if (rnew > 28'sd8388607) begin
      rnew_sat = 24'sh7FFFFF;
    end else if (rnew < -28'sd8388608) begin
      rnew_sat = 24'sh800000;
    end else begin
      rnew_sat = rnew[REWARD_W-1:0];
    end
    num     = {1'b0, p_rdata, 16'd0} + 34'(sum >> 1);
    trial   = {div_rem, div_lo[17]};
    smp_sum = sum + SUMW'(p_rdata);
  end

  // State register and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    cmd_q       <= cmd_next;
    row_base    <= row_base_next;
    pair_q      <= pair_next;
    s2_q        <= s2_next;
    rwd_q       <= rwd_next;
    pv_q        <= pv_next;
    draw_q      <= draw_next;
    idx         <= idx_next;
    sum         <= sum_next;
    p_cur       <= p_cur_next;
    prod        <= prod_next;
    rprod       <= rprod_next;
    div_rem     <= div_rem_next;
    div_lo      <= div_lo_next;
    div_q       <= div_q_next;
    div_cnt     <= div_cnt_next;
    div_sat     <= div_sat_next;
    res_sampled <= res_sampled_next;
    res_pout    <= res_pout_next;
    res_rout    <= res_rout_next;
    res_renorm  <= res_renorm_next;
    if (out_load) begin
      sampled_state   <= res_sampled;
      probability_out <= res_pout;
      expected_reward <= res_rout;
      renormalized    <= res_renorm;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_next       = state;
    cmd_next         = cmd_q;
    row_base_next    = row_base;
    pair_next        = pair_q;
    s2_next          = s2_q;
    rwd_next         = rwd_q;
    pv_next          = pv_q;
    draw_next        = draw_q;
    idx_next         = idx;
    sum_next         = sum;
    p_cur_next       = p_cur;
    prod_next        = prod;
    rprod_next       = rprod;
    div_rem_next     = div_rem;
    div_lo_next      = div_lo;
    div_q_next       = div_q;
    div_cnt_next     = div_cnt;
    div_sat_next     = div_sat;
    res_sampled_next = res_sampled;
    res_pout_next    = res_pout;
    res_rout_next    = res_rout;
    res_renorm_next  = res_renorm;
    out_load         = 1'b0;
    p_we             = 1'b0;
    r_we             = 1'b0;
    p_raddr          = row_base + PAW'(idx);
    p_waddr          = row_base + PAW'(idx);
    p_wdata          = p_new_sat;
    r_wdata          = rnew_sat;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd_next         = cmd_t'(command);
          pair_next        = pair_in;
          row_base_next    = PAW'(PAW'(pair_in) * PAW'(NUM_STATES));
          s2_next          = next_state;
          rwd_next         = reward_value;
          pv_next          = probability_value;
          draw_next        = random_draw;
          idx_next         = '0;
          sum_next         = '0;
          res_sampled_next = '0;
          res_pout_next    = '0;
          res_rout_next    = '0;
          res_renorm_next  = 1'b0;
          if (bad_item) begin
            state_next = ST_DONE;
          end else begin
            unique case (cmd_t'(command))
              CMD_WR_PROB, CMD_WR_REWARD: state_next = ST_WRITE;
              CMD_OBSERVE:                state_next = ST_OBS_RD;
              CMD_SAMPLE:                 state_next = ST_SMP_RD;
              default:                    state_next = ST_RD_ADDR;
            endcase
          end
        end
      end

      ST_WRITE: begin
        if (cmd_q == CMD_WR_PROB) begin
          p_we    = 1'b1;
          p_waddr = row_base + PAW'(s2_q);
          p_wdata = (pv_q > ONE_Q16) ? ONE_Q16 : pv_q;
        end else begin
          r_we    = 1'b1;
          r_wdata = rwd_q;
        end
        state_next = ST_DONE;
      end

      ST_RD_ADDR: begin
        p_raddr    = row_base + PAW'(s2_q);
        state_next = ST_RD_DATA;
      end

      ST_RD_DATA: begin
        res_pout_next = p_rdata;
        res_rout_next = r_rdata;
        state_next    = ST_DONE;
      end

      // Update pass: read, multiply, write back and accumulate the sum
      ST_OBS_RD: begin
        rprod_next = $signed({1'b0, alpha}) * rdiff;
        state_next = ST_OBS_MUL;
      end

      ST_OBS_MUL: begin
        p_cur_next = p_rdata;
        prod_next  = alpha * mul_op;
        state_next = ST_OBS_WR;
      end

      ST_OBS_WR: begin
        p_we     = 1'b1;
        sum_next = sum_acc;
        if (idx == LAST_IDX) begin
          state_next = ST_OBS_CHK;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_OBS_RD;
        end
      end

      ST_OBS_CHK: begin
        r_we     = 1'b1;
        idx_next = '0;
        if (dev > SUMW'(TOL_Q16)) begin
          res_renorm_next = 1'b1;
          state_next      = (sum != '0) ? ST_NRM_RD : ST_DONE;
        end else begin
          state_next = ST_DONE;
        end
      end

      // Renormalize pass: p = (p*65536 + sum/2) / sum, one bit per cycle
      ST_NRM_RD: begin
        state_next = ST_NRM_LD;
      end

      ST_NRM_LD: begin
        div_sat_next = (SUMW'(num[33:18]) >= sum);
        div_rem_next = SUMW'(num[33:18]);
        div_lo_next  = num[17:0];
        div_q_next   = '0;
        div_cnt_next = '0;
        state_next   = ST_NRM_DIV;
      end

      ST_NRM_DIV: begin
        div_lo_next = {div_lo[16:0], 1'b0};
        if (trial >= {1'b0, sum}) begin
          div_rem_next = SUMW'(trial - {1'b0, sum});
          div_q_next   = {div_q[16:0], 1'b1};
        end else begin
          div_rem_next = SUMW'(trial);
          div_q_next   = {div_q[16:0], 1'b0};
        end
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == 5'd17) begin
          state_next = ST_NRM_WR;
        end
      end

      ST_NRM_WR: begin
        p_we    = 1'b1;
        p_wdata = (div_sat || (div_q > 18'(ONE_Q16))) ? ONE_Q16 : div_q[PROB_W-1:0];
        if (idx == LAST_IDX) begin
          state_next = ST_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_NRM_RD;
        end
      end

      // Sample walk: stop at the first cumulative sum above the draw
      ST_SMP_RD: begin
        state_next = ST_SMP_CHK;
      end

      ST_SMP_CHK: begin
        sum_next = smp_sum;
        if (SUMW'(draw_q) < smp_sum) begin
          res_sampled_next = idx;
          state_next       = ST_DONE;
        end else if (idx == LAST_IDX) begin
          state_next = ST_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_SMP_RD;
        end
      end

      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- bench/mdp_tmu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_tmu_checker
// Predicts and checks every result beat of the transition model update block.
// ----------------------------------------------------------------------------
// Watch the command, step-size and result channels. Each accepted command is
// run through a local copy of the probability and reward tables, and the
// predicted result is queued. Each result beat is compared with the oldest
// prediction.
// ----------------------------------------------------------------------------
module mdp_tmu_checker
  import mdp_tmu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [PROB_W-1:0]          cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [CMD_W-1:0]           command,
  input  logic [3:0]                 state_index,
  input  logic [1:0]                 action_index,
  input  logic [3:0]                 next_state,
  input  logic signed [REWARD_W-1:0] reward_value,
  input  logic [PROB_W-1:0]          probability_value,
  input  logic [DRAW_W-1:0]          random_draw,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [3:0]                 sampled_state,
  input  logic [PROB_W-1:0]          probability_out,
  input  logic signed [REWARD_W-1:0] expected_reward,
  input  logic                       renormalized,
  output int                         fail_count,
  output int                         pending
);

  typedef struct {
    logic [3:0]                 sampled;
    logic [PROB_W-1:0]          prob;
    logic signed [REWARD_W-1:0] rwd;
    logic                       renorm;
  } result_t;

  logic [PROB_W-1:0]          prob_mem [1024];
  logic signed [REWARD_W-1:0] rwd_mem  [64];
  longint                     alpha;
  result_t                    expected_results [$];
  int                         reports;

  function automatic longint sat_prob(longint v);
    return (v > 65536) ? 65536 : v;
  endfunction

  function automatic result_t update_model(logic [CMD_W-1:0] cmd, int s, int a, int s2,
                                           logic signed [REWARD_W-1:0] r,
                                           logic [PROB_W-1:0] pv, longint draw);
    result_t res;
    int      base;
    int      pair;
    longint  p;
    longint  sum;
    longint  diff;
    longint  nr;
    res.sampled = '0;
    res.prob    = '0;
    res.rwd     = '0;
    res.renorm  = 1'b0;
    if (cmd > CMD_READ) return res;
    pair = s * 4 + a;
    base = pair * 16;
    case (cmd_t'(cmd))
      CMD_WR_PROB: prob_mem[base + s2] = PROB_W'(sat_prob(longint'(pv)));
      CMD_WR_REWARD: rwd_mem[pair] = r;
      CMD_OBSERVE: begin
        sum = 0;
        for (int i = 0; i < 16; i++) begin
          p = longint'(prob_mem[base + i]);
          if (i == s2) p = p + ((alpha * (65536 - p) + 32768) >> 16);
          else p = p - ((alpha * p + 32768) >> 16);
          p = sat_prob(p);
          prob_mem[base + i] = PROB_W'(p);
          sum += p;
        end
        if (((sum > 65536) ? sum - 65536 : 65536 - sum) > 655) begin
          res.renorm = 1'b1;
          if (sum != 0) begin
            for (int i = 0; i < 16; i++)
              prob_mem[base + i] = PROB_W'(
                sat_prob((longint'(prob_mem[base + i]) * 65536 + sum / 2) / sum));
          end
        end
        diff = longint'(r) - longint'(rwd_mem[pair]);
        nr = longint'(rwd_mem[pair]) + ((alpha * diff + 32768) >>> 16);
        if (nr > 8388607) nr = 8388607;
        if (nr < -8388608) nr = -8388608;
        rwd_mem[pair] = REWARD_W'(nr);
      end
      CMD_SAMPLE: begin
        sum = 0;
        for (int i = 0; i < 16; i++) begin
          sum += longint'(prob_mem[base + i]);
          if (draw < sum) begin
            res.sampled = 4'(i);
            break;
          end
        end
      end
      default: begin
        res.prob = prob_mem[base + s2];
        res.rwd  = rwd_mem[pair];
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      alpha = 6554;
      foreach (prob_mem[i]) prob_mem[i] = '0;
      foreach (rwd_mem[i]) rwd_mem[i] = '0;
      expected_results.delete();
      fail_count = 0;
      reports = 0;
    end else begin
      if (cfg_valid && cfg_ready) alpha = sat_prob(longint'(cfg_data));
      if (in_valid && in_ready)
        expected_results.push_back(update_model(command, state_index, action_index,
                                                next_state, reward_value,
                                                probability_value, random_draw));
      if (out_valid && out_ready) begin
        got.sampled = sampled_state;
        got.prob    = probability_out;
        got.rwd     = expected_reward;
        got.renorm  = renormalized;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (reports < 10) $display("unexpected result beat at %0t", $realtime);
          reports++;
        end else begin
          want = expected_results.pop_front();
          if (got.sampled !== want.sampled || got.prob !== want.prob ||
              got.rwd !== want.rwd || got.renorm !== want.renorm) begin
            fail_count++;
            if (reports < 10)
              $display("result at %0t: expected s=%0d p=%0d r=%0d n=%0d, got s=%0d p=%0d r=%0d n=%0d",
                       $realtime, want.sampled, want.prob, want.rwd, want.renorm,
                       got.sampled, got.prob, got.rwd, got.renorm);
            reports++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- bench/mdp_transition_model_update_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_transition_model_update_test
// Stimulus and verdict for the transition model update block.
// ----------------------------------------------------------------------------
// Run a short directed sequence (saturating writes, extreme rewards, a row
// that needs rescaling, sampling at both draw extremes, an unknown command),
// then six random phases, each under its own step size, with three idle patterns.
// Every row is fully written before it is observed or sampled, so no
// undefined table entry is ever read. The checker does all prediction.
// ----------------------------------------------------------------------------
module mdp_transition_model_update_test;
  import mdp_tmu_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [PROB_W-1:0]          cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CMD_W-1:0]           command = '0;
  logic [3:0]                 state_index = '0;
  logic [1:0]                 action_index = '0;
  logic [3:0]                 next_state = '0;
  logic signed [REWARD_W-1:0] reward_value = '0;
  logic [PROB_W-1:0]          probability_value = '0;
  logic [DRAW_W-1:0]          random_draw = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [3:0]                 sampled_state;
  logic [PROB_W-1:0]          probability_out;
  logic signed [REWARD_W-1:0] expected_reward;
  logic                       renormalized;

  int fail_count;
  int pending;
  int send_idle_pct = 38;
  int recv_idle_pct = 52;
  int stall_cycles = 0;

  // Track which table entries hold data, to keep reads of unwritten ones out.
  bit prob_written [1024];
  bit rwd_written  [64];
  int hot_pairs [6] = '{0, 63, 21, 42, 9, 54};
  logic [PROB_W-1:0] step_sizes [6];

  always #5 clk = ~clk;

  mdp_transition_model_update i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .state_index(state_index), .action_index(action_index),
    .next_state(next_state), .reward_value(reward_value),
    .probability_value(probability_value), .random_draw(random_draw),
    .out_valid(out_valid), .out_ready(out_ready),
    .sampled_state(sampled_state), .probability_out(probability_out),
    .expected_reward(expected_reward), .renormalized(renormalized)
  );

  mdp_tmu_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .state_index(state_index), .action_index(action_index),
    .next_state(next_state), .reward_value(reward_value),
    .probability_value(probability_value), .random_draw(random_draw),
    .out_valid(out_valid), .out_ready(out_ready),
    .sampled_state(sampled_state), .probability_out(probability_out),
    .expected_reward(expected_reward), .renormalized(renormalized),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: drop ready at random per the current idle pattern.
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("mdp_transition_model_update: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Drive one command beat; called and returns on a falling edge.
  task automatic send_command(cmd_t cmd, int s, int a, int s2, int r, int pv, int draw);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command           <= cmd;
    state_index       <= 4'(s);
    action_index      <= 2'(a);
    next_state        <= 4'(s2);
    reward_value      <= REWARD_W'(r);
    probability_value <= PROB_W'(pv);
    random_draw       <= DRAW_W'(draw);
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (cmd == CMD_WR_PROB) prob_written[(s * 4 + a) * 16 + s2] = 1'b1;
    if (cmd == CMD_WR_REWARD) rwd_written[s * 4 + a] = 1'b1;
  endtask

  // Write the step size once the block has drained every result.
  task automatic write_step_size(logic [PROB_W-1:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int draw_probability();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 20000);
  endfunction

  // One random command; fill the missing entries of a row before using it.
  task automatic send_random_command();
    int   pair;
    int   s2;
    int   pick;
    int   hole;
    cmd_t cmd;
    pair = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : hot_pairs[$urandom_range(0, 5)];
    s2   = $urandom_range(0, 15);
    pick = $urandom_range(0, 99);
    hole = -1;
    for (int i = 15; i >= 0; i--) if (!prob_written[pair * 16 + i]) hole = i;
    if (pick < 5) begin
      // Unknown code: the block drops it and answers with zeros.
      command <= 3'($urandom_range(5, 7));
      state_index       <= 4'($urandom);
      action_index      <= 2'($urandom);
      next_state        <= 4'($urandom);
      reward_value      <= REWARD_W'($urandom);
      probability_value <= PROB_W'($urandom);
      random_draw       <= DRAW_W'($urandom);
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
      return;
    end
    if (pick < 20) cmd = CMD_WR_PROB;
    else if (pick < 30) cmd = CMD_WR_REWARD;
    else if (pick < 65) cmd = CMD_OBSERVE;
    else if (pick < 90) cmd = CMD_SAMPLE;
    else cmd = CMD_READ;
    if ((cmd == CMD_OBSERVE || cmd == CMD_SAMPLE) && hole >= 0) begin
      cmd = CMD_WR_PROB;
      s2  = hole;
    end else if (cmd == CMD_READ && !prob_written[pair * 16 + s2]) begin
      cmd = CMD_WR_PROB;
    end
    if ((cmd == CMD_OBSERVE || cmd == CMD_READ) && !rwd_written[pair]) cmd = CMD_WR_REWARD;
    send_command(cmd, pair / 4, pair % 4, s2, $urandom, draw_probability(),
                 $urandom_range(0, 65535));
  endtask

  initial begin
    step_sizes = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd6554, 17'($urandom)};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: pair (15,3) with an empty entry, a saturated one and a full one.
    for (int i = 0; i < 16; i++)
      send_command(CMD_WR_PROB, 15, 3, i, 0, (i == 1) ? 131071 : ((i == 15) ? 65536 : 0), 0);
    send_command(CMD_WR_REWARD, 15, 3, 0, -8388608, 0, 0);
    send_command(CMD_READ, 15, 3, 1, 0, 0, 0);
    send_command(CMD_SAMPLE, 15, 3, 0, 0, 0, 0);
    send_command(CMD_SAMPLE, 15, 3, 0, 0, 0, 65535);
    // Row sums to 2.0: observe rescales it; reward moves from min toward max.
    send_command(CMD_OBSERVE, 15, 3, 15, 8388607, 0, 0);
    send_command(CMD_READ, 15, 3, 15, 0, 0, 0);
    command <= 3'd7;
    state_index <= '1; action_index <= '1; next_state <= '1;
    reward_value <= '1; probability_value <= '1; random_draw <= '1;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    send_command(CMD_WR_REWARD, 15, 3, 0, 8388607, 0, 0);
    send_command(CMD_READ, 15, 3, 0, 0, 0, 0);

    // Random phases: each with its own step size; idle patterns change every two phases.
    for (int phase = 0; phase < 6; phase++) begin
      write_step_size(step_sizes[phase]);
      case (phase / 2)
        0: begin send_idle_pct = 38; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 0) begin
        // With alpha at zero an all-zero row stays at zero sum.
        for (int i = 0; i < 16; i++) send_command(CMD_WR_PROB, 0, 0, i, 0, 0, 0);
        send_command(CMD_WR_REWARD, 0, 0, 0, 12345, 0, 0);
        send_command(CMD_OBSERVE, 0, 0, 3, -4000, 0, 0);
        send_command(CMD_READ, 0, 0, 3, 0, 0, 0);
      end
      repeat (330) send_random_command();
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray beats.
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fail_count == 0) begin
      $display("mdp_transition_model_update: match");
    end else begin
      $display("mdp_transition_model_update: mismatch");
    end
    $finish;
  end

endmodule
